### rtl/sevseg_pkg.sv
// Shared types, codes and tables for the seven-segment display link.
`timescale 1ns / 1ps

package sevseg_pkg;

   localparam int QUEUE_DEPTH = 2;

   // Widths of the request fields
   localparam int TYPE_W  = 2;
   localparam int NUM_W   = 14;
   localparam int POS_W   = 3;
   localparam int SEG_W   = 8;
   localparam int LEVEL_W = 3;

   localparam logic [LEVEL_W-1:0] LEVEL_RESET = 3'd7;

   // Request types
   localparam logic [TYPE_W-1:0] REQ_NUMBER = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_DIGIT  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_BRIGHT = 2'd2;

   // Symbol kinds on the result channel
   localparam logic [1:0] SYM_START = 2'd0;
   localparam logic [1:0] SYM_DATA  = 2'd1;
   localparam logic [1:0] SYM_ACK   = 2'd2;
   localparam logic [1:0] SYM_STOP  = 2'd3;

   // Controller command bytes
   localparam logic [7:0] CMD_AUTO_ADDR   = 8'h40;
   localparam logic [7:0] CMD_FIXED_ADDR  = 8'h44;
   localparam logic [7:0] CMD_ADDR_BASE   = 8'hC0;
   localparam logic [7:0] CMD_BRIGHT_BASE = 8'h87;

   // Divide by 10 as (x * RECIP) >> RECIP_SHIFT, exact for x below 43699
   localparam logic [15:0] RECIP       = 16'd52429;
   localparam int          RECIP_SHIFT = 19;

   // Bytes carried by the second frame at most (address plus four digits)
   localparam int NUM_BYTES  = 5;
   localparam int BYTE_IDX_W = $clog2(NUM_BYTES);
   localparam int BYTE_CNT_W = $clog2(NUM_BYTES + 1);

   // One request, classified: optional one-byte first frame, then a second frame
   typedef struct packed {
      logic                                has_first;
      logic [7:0]                          first_byte;
      logic [BYTE_CNT_W-1:0]               n_bytes;
      logic [NUM_BYTES-1:0][7:0]           bytes;
   } job_type;

   function automatic logic [7:0] seg_of(input logic [3:0] digit);
      logic [7:0] seg;
      case (digit)
         4'd0:    seg = 8'h3F;
         4'd1:    seg = 8'h06;
         4'd2:    seg = 8'h5B;
         4'd3:    seg = 8'h4F;
         4'd4:    seg = 8'h66;
         4'd5:    seg = 8'h6D;
         4'd6:    seg = 8'h7D;
         4'd7:    seg = 8'h07;
         4'd8:    seg = 8'h7F;
         4'd9:    seg = 8'h6F;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage

### rtl/sevseg_front.sv
// Front end: accepts requests, splits numbers into digits and builds frame jobs.
`timescale 1ns / 1ps

module sevseg_front (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic [sevseg_pkg::LEVEL_W-1:0]            level,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [31:0]                               req_tdata,
   input  logic [sevseg_pkg::TYPE_W-1:0]             req_tuser,
   output logic                                      job_valid,
   input  logic                                      job_ready,
   output sevseg_pkg::job_type                       job
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_PUSH = 3'b100
   } front_state_type;

   front_state_type                       state_ff, state_in;
   sevseg_pkg::job_type                   job_ff, job_in;
   logic [sevseg_pkg::NUM_W-1:0]          x_ff, x_in;
   logic [1:0]                            dcnt_ff, dcnt_in;

   logic                                  req_fire;
   logic [29:0]                           prod;
   logic [10:0]                           quot;
   logic [14:0]                           quot10;
   logic [3:0]                            rem;
   logic [sevseg_pkg::BYTE_IDX_W-1:0]     dig_idx;

   assign req_tready = (state_ff == ST_IDLE) || ((state_ff == ST_PUSH) && job_ready);
   assign req_fire   = req_tvalid && req_tready;
   assign job_valid  = (state_ff == ST_PUSH);
   assign job        = job_ff;

   // one decimal digit per cycle, least significant first
   assign prod    = 30'(x_ff) * 30'(sevseg_pkg::RECIP);
   assign quot    = prod[29:sevseg_pkg::RECIP_SHIFT];
   assign quot10  = ({4'b0, quot} << 3) + ({4'b0, quot} << 1);
   assign rem     = 4'(x_ff - quot10[13:0]);
   assign dig_idx = sevseg_pkg::BYTE_IDX_W'(sevseg_pkg::NUM_BYTES - 1)
                    - sevseg_pkg::BYTE_IDX_W'(dcnt_ff);

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      x_in     = x_ff;
      dcnt_in  = dcnt_ff;

      unique case (state_ff)
         ST_CONV: begin
            job_in.bytes[dig_idx] = sevseg_pkg::seg_of(rem);
            x_in    = sevseg_pkg::NUM_W'(quot);
            dcnt_in = dcnt_ff + 2'd1;
            if (dcnt_ff == 2'd3) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (job_ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (req_fire) begin
         unique case (req_tuser)
            sevseg_pkg::REQ_NUMBER: begin
               job_in.has_first  = 1'b1;
               job_in.first_byte = sevseg_pkg::CMD_AUTO_ADDR;
               job_in.n_bytes    = sevseg_pkg::BYTE_CNT_W'(sevseg_pkg::NUM_BYTES);
               job_in.bytes      = '0;
               job_in.bytes[0]   = sevseg_pkg::CMD_ADDR_BASE;
               x_in              = req_tdata[sevseg_pkg::NUM_W-1:0];
               dcnt_in           = 2'd0;
               state_in          = ST_CONV;
            end
            sevseg_pkg::REQ_DIGIT: begin
               job_in.has_first  = 1'b1;
               job_in.first_byte = sevseg_pkg::CMD_FIXED_ADDR;
               job_in.n_bytes    = sevseg_pkg::BYTE_CNT_W'(2);
               job_in.bytes      = '0;
               job_in.bytes[0]   = sevseg_pkg::CMD_ADDR_BASE | {5'b0, req_tdata[16:14]};
               job_in.bytes[1]   = req_tdata[24:17];
               state_in          = ST_PUSH;
            end
            sevseg_pkg::REQ_BRIGHT: begin
               job_in.has_first  = 1'b0;
               job_in.first_byte = '0;
               job_in.n_bytes    = sevseg_pkg::BYTE_CNT_W'(1);
               job_in.bytes      = '0;
               job_in.bytes[0]   = sevseg_pkg::CMD_BRIGHT_BASE + {5'b0, level};
               state_in          = ST_PUSH;
            end
            default: begin
               // unknown request type: dropped, no symbols
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      x_ff    <= x_in;
      dcnt_ff <= dcnt_in;
   end

endmodule

### rtl/sevseg_queue.sv
// Small job queue between the front end and the symbol sequencer.
`timescale 1ns / 1ps

module sevseg_queue #(
   parameter int DEPTH = sevseg_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  sevseg_pkg::job_type  in_job,
   output logic                 out_valid,
   input  logic                 out_ready,
   output sevseg_pkg::job_type  out_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sevseg_pkg::job_type  mem [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_job   = mem[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= in_job;
      end
   end

endmodule

### rtl/sevseg_back.sv
// Back end: walks a job and emits one bus symbol per cycle, unless stalled, into an output register.
`timescale 1ns / 1ps

module sevseg_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_ready,
   input  sevseg_pkg::job_type  job,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic [1:0]           rsp_tuser,
   output logic                 rsp_tlast
);

   typedef enum logic [3:0] {
      SEQ_START = 4'b0001,
      SEQ_DATA  = 4'b0010,
      SEQ_ACK   = 4'b0100,
      SEQ_STOP  = 4'b1000
   } seq_state_type;

   seq_state_type                          seq_ff, seq_in;
   logic                                   busy_ff, busy_in;
   logic                                   first_ff, first_in;
   logic [2:0]                             bit_ff, bit_in;
   logic [sevseg_pkg::BYTE_IDX_W-1:0]      byte_ff, byte_in;
   sevseg_pkg::job_type                    job_ff, job_in;

   logic                                   out_valid_ff, out_valid_in;
   logic [1:0]                             out_kind_ff, out_kind_in;
   logic                                   out_bit_ff, out_bit_in;
   logic                                   out_last_ff, out_last_in;

   logic                                   adv;
   logic                                   last_sym;
   logic                                   load;
   logic [7:0]                             cur_byte;
   logic [1:0]                             sym_kind;
   logic                                   sym_bit;

   assign adv      = busy_ff && (!out_valid_ff || rsp_tready);
   assign last_sym = (seq_ff == SEQ_STOP) && !first_ff;
   // next job loads in the cycle its predecessor's final stop is registered
   assign load      = job_valid && (!busy_ff || (adv && last_sym));
   assign job_ready = load;
   assign cur_byte  = first_ff ? job_ff.first_byte : job_ff.bytes[byte_ff];

   always_comb begin
      unique case (seq_ff)
         SEQ_START: begin
            sym_kind = sevseg_pkg::SYM_START;
            sym_bit  = 1'b0;
         end
         SEQ_DATA: begin
            sym_kind = sevseg_pkg::SYM_DATA;
            sym_bit  = cur_byte[bit_ff];
         end
         SEQ_ACK: begin
            sym_kind = sevseg_pkg::SYM_ACK;
            sym_bit  = 1'b0;
         end
         SEQ_STOP: begin
            sym_kind = sevseg_pkg::SYM_STOP;
            sym_bit  = 1'b0;
         end
         default: begin
            sym_kind = sevseg_pkg::SYM_STOP;
            sym_bit  = 1'b0;
         end
      endcase
   end

   always_comb begin
      seq_in   = seq_ff;
      busy_in  = busy_ff;
      first_in = first_ff;
      bit_in   = bit_ff;
      byte_in  = byte_ff;
      job_in   = job_ff;

      if (adv) begin
         unique case (seq_ff)
            SEQ_START: begin
               seq_in  = SEQ_DATA;
               bit_in  = 3'd0;
               byte_in = '0;
            end
            SEQ_DATA: begin
               if (bit_ff == 3'd7) begin
                  seq_in = SEQ_ACK;
               end else begin
                  bit_in = bit_ff + 3'd1;
               end
            end
            SEQ_ACK: begin
               if (first_ff || (sevseg_pkg::BYTE_CNT_W'(byte_ff) + 1'b1 == job_ff.n_bytes)) begin
                  seq_in = SEQ_STOP;
               end else begin
                  byte_in = byte_ff + 1'b1;
                  bit_in  = 3'd0;
                  seq_in  = SEQ_DATA;
               end
            end
            SEQ_STOP: begin
               if (first_ff) begin
                  first_in = 1'b0;
                  seq_in   = SEQ_START;
               end else begin
                  busy_in = 1'b0;
               end
            end
            default: begin
               seq_in = SEQ_START;
            end
         endcase
      end

      if (load) begin
         job_in   = job;
         first_in = job.has_first;
         seq_in   = SEQ_START;
         bit_in   = 3'd0;
         byte_in  = '0;
         busy_in  = 1'b1;
      end
   end

   always_comb begin
      out_kind_in  = out_kind_ff;
      out_bit_in   = out_bit_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (adv) begin
         out_valid_in = 1'b1;
         out_kind_in  = sym_kind;
         out_bit_in   = sym_bit;
         out_last_in  = last_sym;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_START;
         busy_ff      <= 1'b0;
         first_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         busy_ff      <= busy_in;
         first_ff     <= first_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff      <= bit_in;
      byte_ff     <= byte_in;
      job_ff      <= job_in;
      out_kind_ff <= out_kind_in;
      out_bit_ff  <= out_bit_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, out_bit_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

### rtl/seven_segment_display_link_top.sv
// Top level of the seven-segment display link symbol generator.
// Usage:
//  - req channel takes one display request per word: show a number, set one
//    digit's raw segments, or send the brightness command.
//  - rsp channel gives one bus symbol per word (start, data bit, ack slot,
//    stop); tlast marks the final stop of a request.
//  - csr_we writes the brightness level, taken by later brightness requests.
//  - A number request yields 58 symbols, a digit request 31, a brightness
//    request 11; the sequencer emits one symbol per cycle unless the
//    output is stalled. Back-to-back requests follow each other with no
//    gap.
//  - Requests pass the front, queue and sequencer job registers to the
//    output; numbers first take four divide-by-ten steps, one per cycle.
//  - A two-entry job queue lets the front accept further requests while the
//    sequencer is busy; req_tready drops once the queue and front are full.
//  - When rsp_tready is low the output word holds and the sequencer pauses.
//  - Reset empties the queue, idles both ends and sets brightness to 7.
//  - Request type 3 is accepted and produces no symbols.
`timescale 1ns / 1ps

module seven_segment_display_link_top #(
   parameter int QUEUE_DEPTH = sevseg_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_wdata,   // brightness_level
   input  logic        req_tvalid,
   output logic        req_tready,
   // [13:0] number_value, [16:14] digit_position, [24:17] segment_bits
   input  logic [31:0] req_tdata,
   input  logic [1:0]  req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] bit_value
   output logic [1:0]  rsp_tuser,   // symbol_kind
   output logic        rsp_tlast    // last_symbol
);

   logic [sevseg_pkg::LEVEL_W-1:0] level_ff, level_in;

   logic                 f_valid, f_ready;
   sevseg_pkg::job_type  f_job;
   logic                 b_valid, b_ready;
   sevseg_pkg::job_type  b_job;

   assign level_in = csr_we ? csr_wdata : level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= sevseg_pkg::LEVEL_RESET;
      end else begin
         level_ff <= level_in;
      end
   end

   sevseg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .level      (level_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .job_valid  (f_valid),
      .job_ready  (f_ready),
      .job        (f_job)
   );

   sevseg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_job    (f_job),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_job   (b_job)
   );

   sevseg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (b_valid),
      .job_ready  (b_ready),
      .job        (b_job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### bench/seven_segment_display_link_top_tb.sv
// Self-checking bench for the seven-segment display link symbol generator.
`timescale 1ns / 1ps

module seven_segment_display_link_top_tb;

   localparam logic [sevseg_pkg::TYPE_W-1:0] REQ_NONE = 2'd3;   // accepted, yields no symbols
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 24;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_ITEMS = 85;                // per brightness phase
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [sevseg_pkg::TYPE_W-1:0] kind;
      logic [sevseg_pkg::NUM_W-1:0]  number;
      logic [sevseg_pkg::POS_W-1:0]  pos;
      logic [sevseg_pkg::SEG_W-1:0]  seg;
   } display_req_type;

   // typed rows carry the command byte of a single-frame request
   typedef struct packed {
      display_req_type req;
      logic            typed;
      logic [7:0]      cmd;
   } stim_row_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       bit_v;
      logic       last;
   } bus_symbol_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   bus_symbol_type   pending_symbols[$];
   logic [sevseg_pkg::LEVEL_W-1:0] level_model;
   logic [7:0]       digit_glyph [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                          8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};
   int  mismatches;
   int  symbols_checked;
   int  cycle_count;
   int  req_counts [4];
   bit  hold_pending;

   localparam int N_DIRECTED = 19;
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{'{sevseg_pkg::REQ_BRIGHT, 14'd0,     3'd0, 8'h00}, 1'b1, 8'h8E},
      '{'{sevseg_pkg::REQ_NUMBER, 14'd0,     3'd0, 8'h00}, 1'b0, 8'h00},
      '{'{sevseg_pkg::REQ_NUMBER, 14'd9999,  3'd0, 8'h00}, 1'b0, 8'h00},
      '{'{sevseg_pkg::REQ_NUMBER, 14'd16383, 3'd7, 8'hFF}, 1'b0, 8'h00},
      '{'{sevseg_pkg::REQ_NUMBER, 14'd10000, 3'd0, 8'h00}, 1'b0, 8'h00},
      '{'{sevseg_pkg::REQ_NUMBER, 14'd1234,  3'd0, 8'h00}, 1'b0, 8'h00},
      '{'{sevseg_pkg::REQ_NUMBER, 14'd5678,  3'd0, 8'h00}, 1'b0, 8'h00},
      '{'{sevseg_pkg::REQ_NUMBER, 14'd9081,  3'd0, 8'h00}, 1'b0, 8'h00},
      '{'{sevseg_pkg::REQ_NUMBER, 14'd7,     3'd0, 8'h00}, 1'b0, 8'h00},
      '{'{sevseg_pkg::REQ_DIGIT,  14'd0,     3'd0, 8'h00}, 1'b0, 8'h00},
      '{'{sevseg_pkg::REQ_DIGIT,  14'd0,     3'd5, 8'hFF}, 1'b0, 8'h00},
      '{'{sevseg_pkg::REQ_DIGIT,  14'd0,     3'd6, 8'hA5}, 1'b0, 8'h00},
      '{'{sevseg_pkg::REQ_DIGIT,  14'd16383, 3'd7, 8'h5A}, 1'b0, 8'h00},
      '{'{sevseg_pkg::REQ_DIGIT,  14'd0,     3'd3, 8'h80}, 1'b0, 8'h00},
      '{'{REQ_NONE,               14'd16383, 3'd7, 8'hFF}, 1'b0, 8'h00},
      '{'{REQ_NONE,               14'd0,     3'd0, 8'h00}, 1'b0, 8'h00},
      '{'{sevseg_pkg::REQ_BRIGHT, 14'd16383, 3'd7, 8'hFF}, 1'b1, 8'h8E},
      '{'{REQ_NONE,               14'd4321,  3'd2, 8'h3C}, 1'b0, 8'h00},
      '{'{sevseg_pkg::REQ_BRIGHT, 14'd0,     3'd0, 8'h00}, 1'b1, 8'h8E}
   };

   seven_segment_display_link_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d symbols still expected",
                  cycle_count, pending_symbols.size());
         $display("seven_segment_display_link_top_tb NOT OK");
         $finish;
      end
   end

   // ---------------- symbol predictor ----------------

   function automatic void push_symbol(logic [1:0] kind, logic b, logic last);
      bus_symbol_type s;
      s.kind  = kind;
      s.bit_v = b;
      s.last  = last;
      pending_symbols.push_back(s);
   endfunction

   // eight data bits LSB first, then the ack slot
   function automatic void push_byte(logic [7:0] value);
      for (int i = 0; i < 8; i++)
         push_symbol(sevseg_pkg::SYM_DATA, value[i], 1'b0);
      push_symbol(sevseg_pkg::SYM_ACK, 1'b0, 1'b0);
   endfunction

   function automatic void push_single_frame(logic [7:0] value);
      push_symbol(sevseg_pkg::SYM_START, 1'b0, 1'b0);
      push_byte(value);
      push_symbol(sevseg_pkg::SYM_STOP, 1'b0, 1'b1);
   endfunction

   function automatic void encode_request(display_req_type r);
      logic [7:0] glyph [4];
      int         val;
      case (r.kind)
         sevseg_pkg::REQ_NUMBER: begin
            val = r.number;
            for (int i = 3; i >= 0; i--) begin
               glyph[i] = digit_glyph[val % 10];
               val = val / 10;
            end
            push_symbol(sevseg_pkg::SYM_START, 1'b0, 1'b0);
            push_byte(sevseg_pkg::CMD_AUTO_ADDR);
            push_symbol(sevseg_pkg::SYM_STOP, 1'b0, 1'b0);
            push_symbol(sevseg_pkg::SYM_START, 1'b0, 1'b0);
            push_byte(sevseg_pkg::CMD_ADDR_BASE);
            for (int i = 0; i < 4; i++)
               push_byte(glyph[i]);
            push_symbol(sevseg_pkg::SYM_STOP, 1'b0, 1'b1);
         end
         sevseg_pkg::REQ_DIGIT: begin
            push_symbol(sevseg_pkg::SYM_START, 1'b0, 1'b0);
            push_byte(sevseg_pkg::CMD_FIXED_ADDR);
            push_symbol(sevseg_pkg::SYM_STOP, 1'b0, 1'b0);
            push_symbol(sevseg_pkg::SYM_START, 1'b0, 1'b0);
            push_byte(sevseg_pkg::CMD_ADDR_BASE | {5'd0, r.pos});
            push_byte(r.seg);
            push_symbol(sevseg_pkg::SYM_STOP, 1'b0, 1'b1);
         end
         sevseg_pkg::REQ_BRIGHT:
            push_single_frame(sevseg_pkg::CMD_BRIGHT_BASE + {5'd0, level_model});
         default: ;
      endcase
   endfunction

   function automatic display_req_type random_request();
      display_req_type r;
      int              pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)      r.kind = sevseg_pkg::REQ_NUMBER;
      else if (pick < 70) r.kind = sevseg_pkg::REQ_DIGIT;
      else if (pick < 90) r.kind = sevseg_pkg::REQ_BRIGHT;
      else                r.kind = REQ_NONE;
      if ($urandom_range(0, 9) == 0)
         r.number = sevseg_pkg::NUM_W'($urandom_range(10000, 16383));
      else
         r.number = sevseg_pkg::NUM_W'($urandom_range(0, 9999));
      r.pos = sevseg_pkg::POS_W'($urandom_range(0, 7));
      r.seg = sevseg_pkg::SEG_W'($urandom_range(0, 255));
      return r;
   endfunction

   // ---------------- result checking ----------------

   function automatic void check_field(string name, int expv, int actv);
      if (expv != actv) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("mismatch on symbol %0d: %s expected %0d got %0d",
                     symbols_checked, name, expv, actv);
      end
   endfunction

   always @(posedge clock) begin
      bus_symbol_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_symbols.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected symbol: kind %0d data %0h last %0d",
                        rsp_tuser, rsp_tdata, rsp_tlast);
         end else begin
            want = pending_symbols.pop_front();
            check_field("symbol_kind", want.kind, rsp_tuser);
            check_field("tdata", {7'd0, want.bit_v}, rsp_tdata);
            check_field("last_symbol", want.last, rsp_tlast);
         end
         symbols_checked++;
      end
   end

   // ---------------- receiver stalls ----------------

   initial begin : rsp_stall_pattern
      int mode;
      int run;
      int held;
      rsp_tready = 1'b0;
      held = 0;
      forever begin
         mode = $urandom_range(0, 3);
         run  = $urandom_range(8, 120);
         for (int k = 0; k < run; k++) begin
            @(negedge clock);
            if (hold_pending) begin
               rsp_tready <= 1'b0;
               held++;
               if (held == HOLD_CYCLES) begin
                  hold_pending = 1'b0;
                  held = 0;
               end
            end else begin
               case (mode)
                  0:       rsp_tready <= 1'b1;
                  1:       rsp_tready <= 1'($urandom_range(0, 1));
                  2:       rsp_tready <= ($urandom_range(0, 3) == 0);
                  default: rsp_tready <= k[0];
               endcase
            end
         end
      end
   end

   // ---------------- request driver ----------------

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic offer_request(display_req_type r);
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= {7'd0, r.seg, r.pos, r.number};
      do @(posedge clock); while (!req_tready);
      req_counts[r.kind]++;
      @(negedge clock);
   endtask

   task automatic idle_gap(int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_symbols.size() != 0) @(posedge clock);
      // an ignored request may still be inside the pipe
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_level(logic [sevseg_pkg::LEVEL_W-1:0] lvl);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= lvl;
      @(negedge clock);
      csr_we    <= 1'b0;
      level_model = lvl;
   endtask

   task automatic run_random(int count);
      display_req_type r;
      int              sent;
      int              burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 6);
         for (int j = 0; j < burst && sent < count; j++) begin
            r = random_request();
            offer_request(r);
            encode_request(r);
            sent++;
         end
         idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40));
      end
   endtask

   initial begin
      logic [sevseg_pkg::LEVEL_W-1:0] phase_levels [4];
      display_req_type                r;

      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_wdata    = '0;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      hold_pending = 1'b0;
      mismatches   = 0;
      symbols_checked = 0;
      cycle_count  = 0;
      level_model  = sevseg_pkg::LEVEL_RESET;
      for (int i = 0; i < 4; i++) req_counts[i] = 0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed pass at the reset brightness
      for (int i = 0; i < N_DIRECTED; i++) begin
         offer_request(directed_rows[i].req);
         if (directed_rows[i].typed)
            push_single_frame(directed_rows[i].cmd);
         else
            encode_request(directed_rows[i].req);
         idle_gap(i % 3);
      end

      phase_levels[0] = 3'd0;
      phase_levels[1] = 3'd7;
      phase_levels[2] = 3'd5;
      phase_levels[3] = sevseg_pkg::LEVEL_W'($urandom_range(0, 7));
      for (int p = 0; p < 4; p++) begin
         write_level(phase_levels[p]);
         if (p == 1) begin
            // long output hold-off: the queue fills and req_tready drops
            hold_pending = 1'b1;
            for (int j = 0; j < 8; j++) begin
               r = random_request();
               offer_request(r);
               encode_request(r);
            end
         end
         run_random(RANDOM_ITEMS);
      end

      wait_drained();
      $display("requests: %0d number, %0d digit, %0d brightness, %0d ignored",
               req_counts[sevseg_pkg::REQ_NUMBER], req_counts[sevseg_pkg::REQ_DIGIT],
               req_counts[sevseg_pkg::REQ_BRIGHT], req_counts[REQ_NONE]);
      $display("%0d bus symbols checked over brightness levels 7, 0, 7, 5, %0d",
               symbols_checked, phase_levels[3]);
      if (mismatches == 0) begin
         $display("seven_segment_display_link_top_tb OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("seven_segment_display_link_top_tb NOT OK");
      end
      $finish;
   end

endmodule

### files.f
rtl/sevseg_pkg.sv
rtl/sevseg_front.sv
rtl/sevseg_queue.sv
rtl/sevseg_back.sv
rtl/seven_segment_display_link_top.sv
bench/seven_segment_display_link_top_tb.sv
